// ===== design/f16alu_pkg.sv =====
// shared types, codes and constants of the binary16 elementwise alu
`timescale 1ns / 1ps
package f16alu_pkg;

  // operation register codes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_MAX  = 3'd4;
  localparam logic [2:0] OP_MIN  = 3'd5;
  localparam logic [2:0] OP_RSUB = 3'd6;
  localparam logic [2:0] OP_RDIV = 3'd7;

  // broadcast register codes
  localparam logic [1:0] BC_NONE = 2'd0;
  localparam logic [1:0] BC_B    = 2'd1;
  localparam logic [1:0] BC_A    = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_OPERATION = 2'd0;
  localparam logic [1:0] CFG_BROADCAST = 2'd1;
  localparam logic [1:0] CFG_SCALAR    = 2'd2;

  localparam logic [15:0] CANON_NAN = 16'h7E00;
  localparam logic [14:0] INF_MAG   = 15'h7C00;

  // quotient bits, bits per divider stage, divider stages
  localparam int DivBits   = 16;
  localparam int DivStep   = 4;
  localparam int DivStages = DivBits / DivStep;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  typedef logic signed [6:0] hexp_t;
  typedef logic signed [7:0] exp_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  broadcast;
    logic [15:0] scalar;
  } cfg_t;

  // unpacked operands, mantissas normalized with msb at bit 10
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        spec;
    logic [15:0] spec_val;
    kind_e       kind;
    logic        sx;
    logic        sy;
    hexp_t       ex;
    hexp_t       ey;
    logic [10:0] mx;
    logic [10:0] my;
  } front_t;

  // unrounded result: value = mant * 2^exp, sticky jammed into lsb
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        spec;
    logic [15:0] spec_val;
    logic        sign;
    exp_t        exp;
    logic [25:0] mant;
  } arith_t;

endpackage

// ===== design/f16alu_front.sv =====
// operand select, unpack and special-case stage
`timescale 1ns / 1ps
module f16alu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [15:0]        a_i,
  input  logic [15:0]        b_i,
  input  logic               last_i,
  input  f16alu_pkg::cfg_t   cfg_i,
  output f16alu_pkg::front_t front_o
);

  typedef struct packed {
    logic                nan;
    logic                inf;
    logic                zero;
    logic [10:0]         m;
    f16alu_pkg::hexp_t   e;
  } unp_t;

  function automatic unp_t unpack(input logic [15:0] h);
    unp_t       u;
    logic [4:0] ef;
    logic [9:0] fr;
    logic [3:0] lz;
    ef = h[14:10];
    fr = h[9:0];
    u.nan  = (ef == 5'h1f) && (fr != 10'd0);
    u.inf  = (ef == 5'h1f) && (fr == 10'd0);
    u.zero = (ef == 5'd0) && (fr == 10'd0);
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (fr[i]) lz = 4'(10 - i);
    end
    if (ef != 5'd0) begin
      u.m = {1'b1, fr};
      u.e = $signed({2'b00, ef}) - 7'sd15;
    end else begin
      // subnormal: normalize
      u.m = {1'b0, fr} << lz;
      u.e = -7'sd14 - $signed({3'b000, lz});
    end
    return u;
  endfunction

  function automatic logic [15:0] order_key(input logic [15:0] h);
    logic [15:0] mag;
    mag = {1'b0, h[14:0]};
    return h[15] ? (16'h7fff - mag) : (16'h8000 + mag);
  endfunction

  logic [15:0]        a_sel, b_sel, x, y;
  logic               rev, neg, sx, sy_add, s_mul;
  unp_t               ux, uy;
  logic               a_gt;
  f16alu_pkg::front_t front_d, front_q;

  always_comb begin
    a_sel  = (cfg_i.broadcast == f16alu_pkg::BC_A) ? cfg_i.scalar : a_i;
    b_sel  = (cfg_i.broadcast == f16alu_pkg::BC_B) ? cfg_i.scalar : b_i;
    rev    = (cfg_i.operation == f16alu_pkg::OP_RSUB) || (cfg_i.operation == f16alu_pkg::OP_RDIV);
    neg    = (cfg_i.operation == f16alu_pkg::OP_SUB) || (cfg_i.operation == f16alu_pkg::OP_RSUB);
    x      = rev ? b_sel : a_sel;
    y      = rev ? a_sel : b_sel;
    ux     = unpack(x);
    uy     = unpack(y);
    sx     = x[15];
    sy_add = y[15] ^ neg;
    s_mul  = x[15] ^ y[15];
    a_gt   = order_key(x) > order_key(y);

    front_d.valid    = valid_i;
    front_d.last     = last_i;
    front_d.spec     = 1'b1;
    front_d.spec_val = f16alu_pkg::CANON_NAN;
    front_d.kind     = f16alu_pkg::KIND_ADD;
    front_d.sx       = sx;
    front_d.sy       = sy_add;
    front_d.ex       = ux.e;
    front_d.ey       = uy.e;
    front_d.mx       = ux.m;
    front_d.my       = uy.m;

    unique case (cfg_i.operation)
      f16alu_pkg::OP_ADD, f16alu_pkg::OP_SUB, f16alu_pkg::OP_RSUB: begin
        front_d.kind = f16alu_pkg::KIND_ADD;
        if (ux.nan || uy.nan) begin
          front_d.spec_val = f16alu_pkg::CANON_NAN;
        end else if (ux.inf && uy.inf && (sx != sy_add)) begin
          front_d.spec_val = f16alu_pkg::CANON_NAN;
        end else if (ux.inf) begin
          front_d.spec_val = x;
        end else if (uy.inf) begin
          front_d.spec_val = {sy_add, y[14:0]};
        end else if (ux.zero && uy.zero) begin
          front_d.spec_val = {sx & sy_add, 15'd0};
        end else if (ux.zero) begin
          front_d.spec_val = {sy_add, y[14:0]};
        end else if (uy.zero) begin
          front_d.spec_val = x;
        end else begin
          front_d.spec = 1'b0;
        end
      end
      f16alu_pkg::OP_MUL: begin
        front_d.kind = f16alu_pkg::KIND_MUL;
        front_d.sx   = s_mul;
        if (ux.nan || uy.nan || (ux.inf && uy.zero) || (ux.zero && uy.inf)) begin
          front_d.spec_val = f16alu_pkg::CANON_NAN;
        end else if (ux.inf || uy.inf) begin
          front_d.spec_val = {s_mul, f16alu_pkg::INF_MAG};
        end else if (ux.zero || uy.zero) begin
          front_d.spec_val = {s_mul, 15'd0};
        end else begin
          front_d.spec = 1'b0;
        end
      end
      f16alu_pkg::OP_DIV, f16alu_pkg::OP_RDIV: begin
        front_d.kind = f16alu_pkg::KIND_DIV;
        front_d.sx   = s_mul;
        if (ux.nan || uy.nan || (ux.zero && uy.zero) || (ux.inf && uy.inf)) begin
          front_d.spec_val = f16alu_pkg::CANON_NAN;
        end else if (uy.zero || ux.inf) begin
          front_d.spec_val = {s_mul, f16alu_pkg::INF_MAG};
        end else if (uy.inf || ux.zero) begin
          front_d.spec_val = {s_mul, 15'd0};
        end else begin
          front_d.spec = 1'b0;
        end
      end
      f16alu_pkg::OP_MAX, f16alu_pkg::OP_MIN: begin
        // nan operands are ignored, -0 orders below +0
        if (ux.nan && uy.nan) begin
          front_d.spec_val = f16alu_pkg::CANON_NAN;
        end else if (ux.nan) begin
          front_d.spec_val = y;
        end else if (uy.nan) begin
          front_d.spec_val = x;
        end else if (cfg_i.operation == f16alu_pkg::OP_MAX) begin
          front_d.spec_val = a_gt ? x : y;
        end else begin
          front_d.spec_val = a_gt ? y : x;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ===== design/f16alu_core.sv =====
// add and multiply stage followed by the pipelined radix-2 divider stages
`timescale 1ns / 1ps
module f16alu_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  f16alu_pkg::front_t front_i,
  output f16alu_pkg::arith_t arith_o
);

  typedef struct packed {
    logic                valid;
    logic                last;
    logic                spec;
    logic [15:0]         spec_val;
    logic                is_div;
    logic                sign;
    f16alu_pkg::exp_t    exp;
    logic [25:0]         mant;
    logic [12:0]         div_r;
    logic [15:0]         div_q;
    logic [10:0]         div_y;
  } core_t;

  // DivStep restoring division steps: remainder and quotient so far
  function automatic logic [28:0] div_steps(input logic [12:0] r, input logic [15:0] q,
                                            input logic [10:0] y);
    logic [12:0] rr;
    logic [15:0] qq;
    rr = r;
    qq = q;
    for (int i = 0; i < f16alu_pkg::DivStep; i++) begin
      if (rr >= {2'b00, y}) begin
        rr = rr - {2'b00, y};
        qq = {qq[14:0], 1'b1};
      end else begin
        qq = {qq[14:0], 1'b0};
      end
      rr = {rr[11:0], 1'b0};
    end
    return {rr, qq};
  endfunction

  core_t st_d [f16alu_pkg::DivStages];
  core_t st_q [f16alu_pkg::DivStages];

  logic              swap, sbig, ssml;
  f16alu_pkg::hexp_t ebig, esml;
  logic [10:0]       mbig, msml;
  f16alu_pkg::exp_t  dexp;
  logic [47:0]       al_w;
  logic [23:0]       mb, al;
  logic [24:0]       sum;
  logic              s_add;
  logic [21:0]       prod;
  logic [28:0]       div0;

  always_comb begin
    // alignment for add
    swap = front_i.ey > front_i.ex;
    ebig = swap ? front_i.ey : front_i.ex;
    esml = swap ? front_i.ex : front_i.ey;
    mbig = swap ? front_i.my : front_i.mx;
    msml = swap ? front_i.mx : front_i.my;
    sbig = swap ? front_i.sy : front_i.sx;
    ssml = swap ? front_i.sx : front_i.sy;
    dexp = f16alu_pkg::exp_t'(ebig) - f16alu_pkg::exp_t'(esml);
    al_w = {msml, 37'd0} >> dexp[5:0];
    al   = al_w[47:24] | {23'd0, |al_w[23:0]};
    mb   = {mbig, 13'd0};
    if (sbig == ssml) begin
      sum   = {1'b0, mb} + {1'b0, al};
      s_add = sbig;
    end else if (mb >= al) begin
      sum   = {1'b0, mb - al};
      s_add = sbig;
    end else begin
      sum   = {1'b0, al - mb};
      s_add = ssml;
    end

    prod = front_i.mx * front_i.my;
    div0 = div_steps({2'b00, front_i.mx}, 16'd0, front_i.my);

    st_d[0].valid    = front_i.valid;
    st_d[0].last     = front_i.last;
    st_d[0].spec     = front_i.spec;
    st_d[0].spec_val = front_i.spec_val;
    st_d[0].is_div   = 1'b0;
    st_d[0].div_r    = div0[28:16];
    st_d[0].div_q    = div0[15:0];
    st_d[0].div_y    = front_i.my;
    unique case (front_i.kind)
      f16alu_pkg::KIND_MUL: begin
        st_d[0].sign = front_i.sx;
        st_d[0].exp  = f16alu_pkg::exp_t'(front_i.ex) + f16alu_pkg::exp_t'(front_i.ey)
                       - 8'sd24;
        st_d[0].mant = {prod, 4'd0};
      end
      f16alu_pkg::KIND_DIV: begin
        st_d[0].is_div = 1'b1;
        st_d[0].sign   = front_i.sx;
        st_d[0].exp    = f16alu_pkg::exp_t'(front_i.ex) - f16alu_pkg::exp_t'(front_i.ey)
                         - 8'sd25;
        st_d[0].mant   = '0;
      end
      default: begin
        st_d[0].sign = s_add;
        st_d[0].exp  = f16alu_pkg::exp_t'(ebig) - 8'sd23;
        st_d[0].mant = {1'b0, sum};
      end
    endcase
  end

  for (genvar k = 1; k < f16alu_pkg::DivStages; k++) begin : g_div
    logic [28:0] step;
    always_comb begin
      step    = div_steps(st_q[k-1].div_r, st_q[k-1].div_q, st_q[k-1].div_y);
      st_d[k] = st_q[k-1];
      if (st_q[k-1].is_div) begin
        st_d[k].div_r = step[28:16];
        st_d[k].div_q = step[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < f16alu_pkg::DivStages; k++) st_q[k] <= '0;
    end else begin
      for (int k = 0; k < f16alu_pkg::DivStages; k++) st_q[k] <= st_d[k];
    end
  end

  always_comb begin
    arith_o.valid    = st_q[f16alu_pkg::DivStages-1].valid;
    arith_o.last     = st_q[f16alu_pkg::DivStages-1].last;
    arith_o.spec     = st_q[f16alu_pkg::DivStages-1].spec;
    arith_o.spec_val = st_q[f16alu_pkg::DivStages-1].spec_val;
    arith_o.sign     = st_q[f16alu_pkg::DivStages-1].sign;
    arith_o.exp      = st_q[f16alu_pkg::DivStages-1].exp;
    // nonzero remainder jams into the lsb
    arith_o.mant     = st_q[f16alu_pkg::DivStages-1].is_div ?
                       {st_q[f16alu_pkg::DivStages-1].div_q, 9'd0,
                        |st_q[f16alu_pkg::DivStages-1].div_r} :
                       st_q[f16alu_pkg::DivStages-1].mant;
  end

endmodule

// ===== design/f16alu_round.sv =====
// normalize stage and round-to-nearest-even pack stage
`timescale 1ns / 1ps
module f16alu_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  f16alu_pkg::arith_t arith_i,
  output logic               done_o,
  output logic [15:0]        value_o,
  output logic               last_o
);

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              spec;
    logic [15:0]       spec_val;
    logic              sign;
    logic              zero;
    f16alu_pkg::exp_t  t;
    logic [25:0]       mn;
  } norm_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [15:0] value;
  } out_t;

  norm_t            norm_d, norm_q;
  out_t             out_d, out_q;
  logic [4:0]       lz, sh;
  logic             ov, sub, g, st;
  f16alu_pkg::exp_t shv, tb;
  logic [52:0]      shifted;
  logic [10:0]      q;
  logic [14:0]      base, mag;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 26; i++) begin
      if (arith_i.mant[i]) lz = 5'(25 - i);
    end
    norm_d.valid    = arith_i.valid;
    norm_d.last     = arith_i.last;
    norm_d.spec     = arith_i.spec;
    norm_d.spec_val = arith_i.spec_val;
    norm_d.sign     = arith_i.sign;
    norm_d.zero     = arith_i.mant == 26'd0;
    norm_d.mn       = arith_i.mant << lz;
    // weight of the leading one
    norm_d.t        = arith_i.exp + 8'sd25 - $signed({3'b000, lz});
  end

  always_comb begin
    ov  = norm_q.t > 8'sd15;
    sub = norm_q.t < -8'sd14;
    shv = 8'sd1 - norm_q.t;
    if (!sub) begin
      sh = 5'd15;
    end else if (shv > 8'sd27) begin
      sh = 5'd27;
    end else begin
      sh = shv[4:0];
    end
    shifted = {norm_q.mn, 27'd0} >> sh;
    q    = shifted[37:27];
    g    = shifted[26];
    st   = |shifted[25:0];
    tb   = norm_q.t + 8'sd14;
    base = sub ? 15'd0 : {tb[4:0], 10'd0};
    // a carry out of the mantissa bumps the exponent, up to infinity
    mag  = base + {4'd0, q} + {14'd0, g & (st | q[0])};

    out_d.valid = norm_q.valid;
    out_d.last  = norm_q.last;
    if (norm_q.spec) begin
      out_d.value = norm_q.spec_val;
    end else if (norm_q.zero) begin
      out_d.value = 16'd0;
    end else if (ov) begin
      out_d.value = {norm_q.sign, f16alu_pkg::INF_MAG};
    end else begin
      out_d.value = {norm_q.sign, mag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= '0;
      out_q  <= '0;
    end else begin
      norm_q <= norm_d;
      out_q  <= out_d;
    end
  end

  assign done_o  = out_q.valid;
  assign value_o = out_q.value;
  assign last_o  = out_q.last;

endmodule

// ===== design/fp16_elementwise_binary_alu.sv =====
// top level of the binary16 elementwise alu: registers, pipeline and checks
//
//  channel   handshake          payload
//  command   start_i / busy_o   operand_a_i, operand_b_i, last_in_i
//  result    done_o (strobe)    result_value_o, last_out_o
//  config    cfg_we_i           cfg_index_i, cfg_wdata_i
//
// a word is taken every cycle; each result follows its command through the unpack
// stage, the four divider stages (4 quotient bits each), then the normalize and
// round stages; every operation uses that path
// busy_o stays low, the receiver cannot stall, so the pipeline never holds
// reset clears the registers and the pipeline valid bits
`timescale 1ns / 1ps
module fp16_elementwise_binary_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic        last_in_i,
  output logic        done_o,
  output logic [15:0] result_value_o,
  output logic        last_out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  f16alu_pkg::cfg_t   cfg_q;
  f16alu_pkg::front_t front;
  f16alu_pkg::arith_t arith;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        f16alu_pkg::CFG_OPERATION: cfg_q.operation <= cfg_wdata_i[2:0];
        f16alu_pkg::CFG_BROADCAST: cfg_q.broadcast <= cfg_wdata_i[1:0];
        f16alu_pkg::CFG_SCALAR:    cfg_q.scalar    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  f16alu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .last_i  (last_in_i),
    .cfg_i   (cfg_q),
    .front_o (front)
  );

  f16alu_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front),
    .arith_o (arith)
  );

  f16alu_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .arith_i (arith),
    .done_o  (done_o),
    .value_o (result_value_o),
    .last_o  (last_out_o)
  );

  // every command yields its result
  a_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##7 done_o)
    else $error("command word lost in pipeline");

  a_done_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 7))
    else $error("result word without a command");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (last_out_o == $past(last_in_i, 7)))
    else $error("last flag not carried with its word");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the binary16 elementwise alu
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [15:0] a;
    logic [15:0] b;
    logic        last;
  } word_t;

  typedef struct {
    logic [15:0] value;
    logic        last;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] operand_a_i = '0;
  logic [15:0] operand_b_i = '0;
  logic        last_in_i = 1'b0;
  logic        done_o;
  logic [15:0] result_value_o;
  logic        last_out_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  word_t    word_q[$];
  outcome_t outcome_q[$];
  logic [2:0]  op_now = f16alu_pkg::OP_ADD;
  logic [1:0]  bc_now = f16alu_pkg::BC_NONE;
  logic [15:0] scalar_now = '0;
  int errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_settings = 0;
  int gap = 0;
  bit no_idle = 0;

  fp16_elementwise_binary_alu uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit half_nan(logic [15:0] h);
    return h[14:0] > f16alu_pkg::INF_MAG;
  endfunction

  function automatic real half_to_real(logic [15:0] h);
    real v;
    if (h[14:10] == 5'h1F) begin
      if (h[9:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      return $bitstoreal({h[15], 63'h7FF0_0000_0000_0000});
    end
    if (h[14:10] == 0) begin
      v = real'(h[9:0]) * 5.9604644775390625e-08;
      return h[15] ? -v : v;
    end
    return $bitstoreal({h[15], 11'(int'(h[14:10]) - 15 + 1023), h[9:0], 42'd0});
  endfunction

  function automatic logic [15:0] real_to_half(real d);
    logic [63:0] u, m, q, rem, hb;
    logic [15:0] s, base;
    int e, sh, extra;
    u = $realtobits(d);
    s = {u[63], 15'd0};
    if (u[62:52] == 11'h7FF) begin
      return (u[51:0] != 0) ? f16alu_pkg::CANON_NAN : (s | 16'h7C00);
    end
    if (u[62:52] == 0) return s;
    e = int'(u[62:52]) - 1023;
    if (e > 15) return s | 16'h7C00;
    m = {11'd0, 1'b1, u[51:0]};
    sh = 42;
    base = '0;
    if (e >= -14) begin
      base = 16'((e + 14) << 10);
    end else begin
      extra = -14 - e;
      sh = (extra > 21) ? 63 : 42 + extra;
    end
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 64'd1);
    hb = 64'd1 << (sh - 1);
    if (rem > hb || (rem == hb && q[0])) q = q + 1;
    return s | ((base + q[15:0]) & 16'h7FFF);
  endfunction

  function automatic logic [15:0] order_key(logic [15:0] h);
    return h[15] ? (16'h7FFF - {1'b0, h[14:0]}) : (16'h8000 + {1'b0, h[14:0]});
  endfunction

  function automatic logic [15:0] pick_extreme(logic [15:0] x, logic [15:0] y, bit want_max);
    bit gt;
    if (half_nan(x) && half_nan(y)) return f16alu_pkg::CANON_NAN;
    if (half_nan(x)) return y;
    if (half_nan(y)) return x;
    gt = order_key(x) > order_key(y);
    return (want_max ^ !gt) ? x : y;
  endfunction

  function automatic logic [15:0] quotient(logic [15:0] x, logic [15:0] y);
    if (y[14:0] == 0) begin
      if (x[14:0] == 0 || half_nan(x)) return f16alu_pkg::CANON_NAN;
      return {x[15] ^ y[15], f16alu_pkg::INF_MAG};
    end
    return real_to_half(half_to_real(x) / half_to_real(y));
  endfunction

  function automatic logic [15:0] alu_result(word_t w);
    logic [15:0] a, b;
    a = w.a;
    b = w.b;
    if (bc_now == f16alu_pkg::BC_B) b = scalar_now;
    else if (bc_now == f16alu_pkg::BC_A) a = scalar_now;
    case (op_now)
      f16alu_pkg::OP_ADD:  return real_to_half(half_to_real(a) + half_to_real(b));
      f16alu_pkg::OP_SUB:  return real_to_half(half_to_real(a) - half_to_real(b));
      f16alu_pkg::OP_MUL:  return real_to_half(half_to_real(a) * half_to_real(b));
      f16alu_pkg::OP_DIV:  return quotient(a, b);
      f16alu_pkg::OP_MAX:  return pick_extreme(a, b, 1'b1);
      f16alu_pkg::OP_MIN:  return pick_extreme(a, b, 1'b0);
      f16alu_pkg::OP_RSUB: return real_to_half(half_to_real(b) - half_to_real(a));
      default:             return quotient(b, a);
    endcase
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: accept check, then next word
  always @(posedge clk_i) begin
    word_t w;
    if (start_i && !busy_o) begin
      w.a = operand_a_i;
      w.b = operand_b_i;
      w.last = last_in_i;
      outcome_q.push_back('{alu_result(w), last_in_i});
      n_accepted++;
    end
    if (!(start_i && busy_o)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start_i <= 1'b0;
      end else if (word_q.size() > 0) begin
        w = word_q.pop_front();
        operand_a_i <= w.a;
        operand_b_i <= w.b;
        last_in_i <= w.last;
        start_i <= 1'b1;
        gap <= draw_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h (op %0d bc %0d scalar %h)",
             what, got, want, op_now, bc_now, scalar_now);
    errors++;
  endtask

  // monitor
  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected word", result_value_o, 16'h0);
      end else begin
        o = outcome_q.pop_front();
        n_checked++;
        if (result_value_o !== o.value) report_mismatch("result_value", result_value_o, o.value);
        if (last_out_o !== o.last) report_mismatch("last_out", 16'(last_out_o), 16'(o.last));
      end
    end
  end

  task automatic wait_idle();
    while (word_q.size() > 0 || start_i || outcome_q.size() > 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      f16alu_pkg::CFG_OPERATION: op_now = val[2:0];
      f16alu_pkg::CFG_BROADCAST: bc_now = val[1:0];
      default:                   scalar_now = val;
    endcase
  endtask

  task automatic set_config(logic [2:0] op, logic [1:0] bc, logic [15:0] sc);
    wait_idle();
    write_reg(f16alu_pkg::CFG_OPERATION, 16'(op));
    write_reg(f16alu_pkg::CFG_BROADCAST, 16'(bc));
    write_reg(f16alu_pkg::CFG_SCALAR, sc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_half();
    logic [15:0] specials[12] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                  16'h7C01, 16'hFFFF, 16'h0001, 16'h83FF, 16'h0400,
                                  16'h7BFF, 16'h3C00};
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return specials[$urandom_range(0, 11)];
    if (r < 5) return {1'($urandom), 5'($urandom_range(0, 2)), 10'($urandom)};
    return 16'($urandom);
  endfunction

  task automatic push_word(logic [15:0] a, logic [15:0] b, logic last);
    word_q.push_back('{a, b, last});
  endtask

  initial begin
    logic [15:0] dir_a[6] = '{16'h7BFF, 16'h0001, 16'h7C01, 16'h0000, 16'hFC00, 16'h8000};
    logic [15:0] dir_b[6] = '{16'h7BFF, 16'h8001, 16'h3C00, 16'h8000, 16'h7C00, 16'hFE00};
    logic [15:0] sc_list[6] = '{16'h0000, 16'hFFFF, 16'h7C01, 16'h8000, 16'h0001, 16'h7BFF};
    logic [15:0] a, b;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: even operations on overflow, nan and infinity pairs, odd on subnormal, zero and nan
    for (int op = 0; op < 8; op++) begin
      set_config(3'(op), f16alu_pkg::BC_NONE, 16'h0000);
      for (int k = 0; k < 3; k++) push_word(dir_a[(op + 2 * k) % 6], dir_b[(op + 2 * k) % 6],
                                            1'(k == 2));
    end
    // random settings, extremes of broadcast and scalar included
    for (int ph = 0; ph < 40; ph++) begin
      set_config(3'($urandom), (ph % 5 == 4) ? 2'd3 : 2'($urandom_range(0, 2)),
                 (ph % 2) ? sc_list[$urandom_range(0, 5)] : 16'($urandom));
      no_idle = (ph % 4 == 0);
      for (int k = 0; k < 25; k++) begin
        a = rand_half();
        b = ($urandom_range(0, 7) == 0) ? (a ^ 16'($urandom_range(0, 3))) : rand_half();
        if ($urandom_range(0, 9) == 0) b = a ^ 16'h8000;
        push_word(a, b, 1'($urandom));
      end
    end
    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("run covered %0d words over %0d register settings, %0d results checked",
             n_accepted, n_settings, n_checked);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("** fp16_elementwise_binary_alu: PASSED **");
    end else begin
      $display("** fp16_elementwise_binary_alu: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("** fp16_elementwise_binary_alu: FAILED **");
    $finish;
  end

endmodule
